[rtl/ghsp_pkg.sv]
// ghsp_pkg: shared types, codes and field widths of the generational handle slot pool
// no dependencies; compiled before every other file of the block
`default_nettype none

package ghsp_pkg;

    // default sizing of the pool
    localparam int SLOT_COUNT_DEF = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int SIZE_BITS_DEF  = 24;

    // request field widths
    localparam int FUNC_W      = 2;
    localparam int REQ_BYTES_W = 24;
    localparam int HSLOT_W     = 7;
    localparam int HGEN_W      = 16;

    // response field widths
    localparam int STATUS_W = 2;
    localparam int RSLOT_W  = 6;
    localparam int RGEN_W   = 16;
    localparam int EBYTES_W = 24;
    localparam int BYTES_W  = 30;
    localparam int TOTAL_W  = 32;

    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ACCESS  = 2'd2;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_STALE = 2'd3
    } status_t;

    // request sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // live map update command
    typedef struct packed {
        logic set;
        logic clear;
    } live_upd_t;

endpackage

`default_nettype wire

[rtl/ghsp_if.sv]
// ghsp_if: valid/ready channel interfaces for the request and response sides
// depends on ghsp_pkg for the payload widths
`default_nettype none

interface ghsp_req_if;
    import ghsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [HSLOT_W-1:0]     handle_slot;
    logic [HGEN_W-1:0]      handle_generation;

    modport source (
        output valid, func, request_bytes, handle_slot, handle_generation,
        input  ready
    );

    modport sink (
        input  valid, func, request_bytes, handle_slot, handle_generation,
        output ready
    );
endinterface

interface ghsp_rsp_if;
    import ghsp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RSLOT_W-1:0]  result_slot;
    logic [RGEN_W-1:0]   result_generation;
    logic [EBYTES_W-1:0] entry_bytes;
    logic [BYTES_W-1:0]  bytes_outstanding;
    logic [BYTES_W-1:0]  peak_bytes;
    logic [TOTAL_W-1:0]  alloc_total;
    logic [TOTAL_W-1:0]  release_total;

    modport source (
        output valid, status, result_slot, result_generation, entry_bytes,
               bytes_outstanding, peak_bytes, alloc_total, release_total,
        input  ready
    );

    modport sink (
        input  valid, status, result_slot, result_generation, entry_bytes,
               bytes_outstanding, peak_bytes, alloc_total, release_total,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ghsp_slot_mem.sv]
// ghsp_slot_mem: synchronous slot table holding generation and size per slot
// one write port, one read port with registered read data; no reset on contents
`default_nettype none

module ghsp_slot_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 40,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/ghsp_live_map.sv]
// ghsp_live_map: live bit per slot with lowest-free-slot priority search
// depends on ghsp_pkg for the update command struct
`default_nettype none

module ghsp_live_map #(
    parameter int SLOT_COUNT = 64,
    parameter int SLOT_W     = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ghsp_pkg::live_upd_t upd,
    input  wire logic [SLOT_W-1:0] upd_idx,
    input  wire logic [SLOT_W-1:0] probe_idx,
    output logic                   probe_live,
    output logic                   free_found,
    output logic      [SLOT_W-1:0] free_idx
);
    import ghsp_pkg::*;

    logic [SLOT_COUNT-1:0] live_reg;
    logic [SLOT_COUNT-1:0] live_next;

    // set on allocate, clear on release
    always_comb
    begin
        live_next = live_reg;
        if (upd.set)
        begin
            live_next[upd_idx] = 1'b1;
        end
        if (upd.clear)
        begin
            live_next[upd_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    // lowest clear bit; unopened slots are never live, so this also
    // lands on the next unopened slot once every opened slot is live
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // live bit of the handle slot
    assign probe_live = live_reg[probe_idx];

endmodule

`default_nettype wire

[rtl/generational_handle_slot_pool.sv]
// generational_handle_slot_pool: top level, request sequencer, counters, response register
// depends on ghsp_pkg, ghsp_if, ghsp_slot_mem and ghsp_live_map
//
// Usage:
//   req channel (sink): func selects allocate, release or access; allocate
//   uses request_bytes, release and access use handle_slot/handle_generation.
//   rsp channel (source): one transaction per request with status, slot,
//   generation, entry size and the running byte and transaction counters.
// Sequencing:
//   a request is taken in idle; the slot table read issued on that edge
//   returns in execute, and the update and response are registered on the
//   edge that commits the request. A new request is taken only after the
//   sequencer is back in idle, so the read-modify-write of the slot table
//   for one request completes before the next request is accepted.
// Stalls:
//   the response register frees the request side while a response waits;
//   a second request then waits in execute until the response is taken.
// Reset:
//   rst_n clears the live map, the opened-slot count, the byte counters and
//   the transaction counters. The slot table needs no clearing pass: an
//   entry is only used once the opened-slot count covers it, and a newly
//   opened slot starts from generation zero.
`default_nettype none

module generational_handle_slot_pool #(
    parameter int SLOT_COUNT = ghsp_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = ghsp_pkg::GEN_BITS_DEF,
    parameter int SIZE_BITS  = ghsp_pkg::SIZE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ghsp_req_if.sink    req,
    ghsp_rsp_if.source  rsp
);
    import ghsp_pkg::*;

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W   = (CNT_W > HSLOT_W) ? CNT_W : HSLOT_W;
    localparam int ENTRY_W = GEN_BITS + SIZE_BITS;
    localparam int ACC_W   = ((BYTES_W > SIZE_BITS) ? BYTES_W : SIZE_BITS) + 1;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   commit;

    // captured request
    logic [FUNC_W-1:0]    func_reg;
    logic [SIZE_BITS-1:0] req_size_reg;
    logic [CMP_W-1:0]     hslot_reg;
    logic [GEN_BITS-1:0]  hgen_reg;
    logic                 in_range_reg;
    logic                 live_hit_reg;
    logic                 free_found_reg;
    logic [SLOT_W-1:0]    free_idx_reg;

    // pool state
    logic [CNT_W-1:0]   slots_opened_reg;
    logic [CNT_W-1:0]   slots_opened_next;
    logic [BYTES_W-1:0] bytes_in_use_reg;
    logic [BYTES_W-1:0] bytes_in_use_next;
    logic [BYTES_W-1:0] bytes_peak_reg;
    logic [BYTES_W-1:0] bytes_peak_next;
    logic [TOTAL_W-1:0] alloc_counter_reg;
    logic [TOTAL_W-1:0] alloc_counter_next;
    logic [TOTAL_W-1:0] release_counter_reg;
    logic [TOTAL_W-1:0] release_counter_next;

    // response register
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [RSLOT_W-1:0]  rslot_reg;
    logic [RSLOT_W-1:0]  rslot_next;
    logic [RGEN_W-1:0]   rgen_reg;
    logic [RGEN_W-1:0]   rgen_next;
    logic [EBYTES_W-1:0] rbytes_reg;
    logic [EBYTES_W-1:0] rbytes_next;
    logic [BYTES_W-1:0]  out_bytes_reg;
    logic [BYTES_W-1:0]  out_peak_reg;
    logic [TOTAL_W-1:0]  out_alloc_reg;
    logic [TOTAL_W-1:0]  out_release_reg;

    // request decode at accept
    logic [CMP_W-1:0]    hslot_ext;
    logic [SLOT_W-1:0]   hslot_addr;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic                probe_live;
    logic [SLOT_W-1:0]   rd_addr;

    // slot table
    logic [ENTRY_W-1:0]   rd_data;
    logic [GEN_BITS-1:0]  rd_gen;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 mem_wr_en;
    logic [ENTRY_W-1:0]   mem_wr_data;
    live_upd_t            live_upd;
    logic [SLOT_W-1:0]    live_upd_idx;

    // execute datapath
    logic                 is_new;
    logic [GEN_BITS-1:0]  old_gen;
    logic [GEN_BITS-1:0]  new_gen;
    logic [ACC_W-1:0]     add_sum;
    logic [BYTES_W-1:0]   add_sat;
    logic [ACC_W-1:0]     in_use_ext;
    logic [ACC_W-1:0]     rd_size_ext;
    logic [BYTES_W-1:0]   sub_sat;
    logic                 hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_EXEC: commit    = !rsp_valid_reg || rsp.ready;
            default: req.ready = 1'b0;
        endcase
    end

    assign accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // handle decode and table read address
    assign hslot_ext  = CMP_W'(req.handle_slot);
    assign hslot_addr = hslot_ext[SLOT_W-1:0];
    assign rd_addr    = (req.func == FUNC_ALLOC) ? free_idx : hslot_addr;

    ghsp_live_map #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_live_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (live_upd),
        .upd_idx    (live_upd_idx),
        .probe_idx  (hslot_addr),
        .probe_live (probe_live),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    ghsp_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (ENTRY_W),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (live_upd_idx),
        .wr_data (mem_wr_data)
    );

    // capture the request transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= req.func;
            req_size_reg   <= SIZE_BITS'(req.request_bytes);
            hslot_reg      <= hslot_ext;
            hgen_reg       <= GEN_BITS'(req.handle_generation);
            in_range_reg   <= hslot_ext < CMP_W'(slots_opened_reg);
            live_hit_reg   <= probe_live;
            free_found_reg <= free_found;
            free_idx_reg   <= free_idx;
        end
    end

    // table entry fields and derived values
    assign rd_gen  = rd_data[ENTRY_W-1:SIZE_BITS];
    assign rd_size = rd_data[SIZE_BITS-1:0];
    assign is_new  = CNT_W'(free_idx_reg) == slots_opened_reg;
    assign old_gen = is_new ? '0 : rd_gen;
    assign new_gen = old_gen + GEN_BITS'(1);
    assign hit     = live_hit_reg && (rd_gen == hgen_reg);

    // saturating byte accounting
    assign in_use_ext  = ACC_W'(bytes_in_use_reg);
    assign rd_size_ext = ACC_W'(rd_size);
    assign add_sum     = in_use_ext + ACC_W'(req_size_reg);
    assign add_sat     = (add_sum > ACC_W'(BYTES_MAX)) ? BYTES_MAX : add_sum[BYTES_W-1:0];
    assign sub_sat     = (in_use_ext > rd_size_ext)
                       ? BYTES_W'(in_use_ext - rd_size_ext) : '0;

    assign mem_wr_data = {new_gen, req_size_reg};

    // execute: check handle, update state, build response
    always_comb
    begin
        slots_opened_next    = slots_opened_reg;
        bytes_in_use_next    = bytes_in_use_reg;
        bytes_peak_next      = bytes_peak_reg;
        alloc_counter_next   = alloc_counter_reg;
        release_counter_next = release_counter_reg;
        mem_wr_en            = 1'b0;
        live_upd             = '0;
        live_upd_idx         = hslot_reg[SLOT_W-1:0];
        status_next          = STATUS_OK;
        rslot_next           = RSLOT_W'(hslot_reg);
        rgen_next            = '0;
        rbytes_next          = '0;

        case (func_reg)
            FUNC_ALLOC:
            begin
                live_upd_idx = free_idx_reg;
                rslot_next   = '0;
                if (!free_found_reg)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    rslot_next  = RSLOT_W'(free_idx_reg);
                    rgen_next   = RGEN_W'(new_gen);
                    rbytes_next = EBYTES_W'(req_size_reg);
                    if (commit)
                    begin
                        mem_wr_en          = 1'b1;
                        live_upd.set       = 1'b1;
                        bytes_in_use_next  = add_sat;
                        alloc_counter_next = alloc_counter_reg + TOTAL_W'(1);
                        if (add_sat > bytes_peak_reg)
                        begin
                            bytes_peak_next = add_sat;
                        end
                        if (is_new)
                        begin
                            slots_opened_next = slots_opened_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                if (!in_range_reg)
                begin
                    status_next = STATUS_RANGE;
                end
                else if (!hit)
                begin
                    status_next = STATUS_STALE;
                    rgen_next   = RGEN_W'(rd_gen);
                end
                else
                begin
                    rgen_next   = RGEN_W'(rd_gen);
                    rbytes_next = EBYTES_W'(rd_size);
                    if (commit && (func_reg == FUNC_RELEASE))
                    begin
                        live_upd.clear       = 1'b1;
                        bytes_in_use_next    = sub_sat;
                        release_counter_next = release_counter_reg + TOTAL_W'(1);
                    end
                end
            end
        endcase
    end

    // pool counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_opened_reg    <= '0;
            bytes_in_use_reg    <= '0;
            bytes_peak_reg      <= '0;
            alloc_counter_reg   <= '0;
            release_counter_reg <= '0;
        end
        else
        begin
            slots_opened_reg    <= slots_opened_next;
            bytes_in_use_reg    <= bytes_in_use_next;
            bytes_peak_reg      <= bytes_peak_next;
            alloc_counter_reg   <= alloc_counter_next;
            release_counter_reg <= release_counter_next;
        end
    end

    // response valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg      <= status_next;
            rslot_reg       <= rslot_next;
            rgen_reg        <= rgen_next;
            rbytes_reg      <= rbytes_next;
            out_bytes_reg   <= bytes_in_use_next;
            out_peak_reg    <= bytes_peak_next;
            out_alloc_reg   <= alloc_counter_next;
            out_release_reg <= release_counter_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.result_slot       = rslot_reg;
    assign rsp.result_generation = rgen_reg;
    assign rsp.entry_bytes       = rbytes_reg;
    assign rsp.bytes_outstanding = out_bytes_reg;
    assign rsp.peak_bytes        = out_peak_reg;
    assign rsp.alloc_total       = out_alloc_reg;
    assign rsp.release_total     = out_release_reg;

    // opened-slot count stays within the pool
    a_opened_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_opened_reg <= CNT_W'(SLOT_COUNT))
        else $error("opened slot count beyond pool size");

    // high-water mark never below bytes in use
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_peak_reg >= bytes_in_use_reg)
        else $error("peak bytes below bytes in use");

    // no free slot only when every slot has been opened
    a_full_only_when_opened: assert property (@(posedge clk) disable iff (!rst_n)
        !free_found |-> (slots_opened_reg == CNT_W'(SLOT_COUNT)))
        else $error("free search failed with unopened slots left");

    // an accepted request is executed on the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execute");

    // a committed response is presented on the next cycle
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg)
        else $error("committed request produced no response");

endmodule

`default_nettype wire
